@@ sv/cta_pkg.sv @@
// Shared types and constants for the color-to-alpha unmix pipeline.
// No dependencies.
package cta_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned DvdW    = 19;   // dividend and remainder width
  localparam int unsigned DvsW    = ChW + 1;
  localparam int unsigned NLanes  = 4;    // red, green, blue, alpha
  localparam int unsigned NSteps  = ChW;  // one quotient bit per stage

  localparam logic [ChW-1:0] ChMax = 8'd255;

  typedef logic [ChW-1:0] chan_t;
  typedef chan_t [2:0]    rgb_t;

  typedef enum logic [1:0] {
    REG_BG_RED   = 2'd0,
    REG_BG_GREEN = 2'd1,
    REG_BG_BLUE  = 2'd2
  } reg_idx_e;

  // Front end to divider hand-off.
  typedef struct packed {
    logic [NLanes-1:0][DvdW-1:0] dvd;
    logic [NLanes-1:0][DvsW-1:0] dvs;
    logic [2:0]                  neg;
    logic                        none;
    rgb_t                        src;
  } mid_t;

  // One divider stage.
  typedef struct packed {
    logic [NLanes-1:0][DvdW-1:0] rem;
    logic [NLanes-1:0][DvsW-1:0] dvs;
    logic [NLanes-1:0][ChW-1:0]  quo;
    logic [2:0]                  neg;
    logic [2:0]                  sat;
    logic                        none;
    rgb_t                        src;
  } dstg_t;

endpackage

@@ sv/colour_to_alpha_unmix.sv @@
// Top level of the color-to-alpha unmix block: background registers, front end, divider.
// Depends on cta_pkg, cta_front, cta_div.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid_i/in_ready_o  | src_red_i, src_green_i, src_blue_i, src_alpha_i
//  out     | out_valid_o/out_ready_i| out_red_o, out_green_o, out_blue_o, out_alpha_o
//  cfg     | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while out_ready_i is not held low (3 front-end stages,
// one saturation stage, 8 divider stages, one quotient bit each).
// Reset clears all valid bits and sets the background to white.
// Each stage loads when it is empty or its successor moves, so a stalled
// output only backs up the stages behind it; nothing is dropped or repeated.
module colour_to_alpha_unmix import cta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_alpha_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  rgb_t bg_q;
  rgb_t src;
  rgb_t out_rgb;
  mid_t mid;
  logic mid_valid, mid_ready;

  // background color registers; an unknown index is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= {ChMax, ChMax, ChMax};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BG_RED:   bg_q[0] <= cfg_data_i;
        REG_BG_GREEN: bg_q[1] <= cfg_data_i;
        REG_BG_BLUE:  bg_q[2] <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign src = {src_blue_i, src_green_i, src_red_i};

  // distances, winning fraction, and the unmix/alpha dividends
  cta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bg_i        (bg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_i       (src),
    .alpha_i     (src_alpha_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  // rounded quotients, clamp, and background-match pass-through
  cta_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rgb_o   (out_rgb),
    .out_alpha_o (out_alpha_o)
  );

  assign out_red_o   = out_rgb[0];
  assign out_green_o = out_rgb[1];
  assign out_blue_o  = out_rgb[2];

endmodule

@@ sv/cta_front.sv @@
// Front end: distances, fraction compare, winner pick and dividends (three stages).
// Depends on cta_pkg.
module cta_front import cta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  rgb_t  bg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  rgb_t  src_i,
  input  chan_t alpha_i,
  output logic  mid_valid_o,
  input  logic  mid_ready_i,
  output mid_t  mid_o
);

  logic [2:0] en;
  logic [2:0] v_q;

  // stage 1: distance and headroom
  rgb_t  s1_q, b1_q, d1_q, den1_q, d1_d, den1_d;
  chan_t a1_q;
  // stage 2: pairwise fraction compares
  rgb_t  s2_q, b2_q, d2_q, den2_q;
  chan_t a2_q;
  logic  gt01_q, gt02_q, gt12_q, gt01_d, gt02_d, gt12_d;
  // stage 3: dividends
  mid_t  mid_q, mid_d;

  always_comb begin
    en[2] = !v_q[2] || mid_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end
  assign in_ready_o  = en[0];
  assign mid_valid_o = v_q[2];
  assign mid_o       = mid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (src_i[i] < bg_i[i]) begin
        d1_d[i]   = bg_i[i] - src_i[i];
        den1_d[i] = bg_i[i];
      end else begin
        d1_d[i]   = src_i[i] - bg_i[i];
        den1_d[i] = ChMax - bg_i[i];
      end
    end
  end

  // d_j/den_j > d_i/den_i by cross-multiplication
  always_comb begin
    gt01_d = (16'(d1_q[1]) * 16'(den1_q[0])) > (16'(d1_q[0]) * 16'(den1_q[1]));
    gt02_d = (16'(d1_q[2]) * 16'(den1_q[0])) > (16'(d1_q[0]) * 16'(den1_q[2]));
    gt12_d = (16'(d1_q[2]) * 16'(den1_q[1])) > (16'(d1_q[1]) * 16'(den1_q[2]));
  end

  logic [1:0]        win;
  logic              have;
  chan_t             dk, denk;
  logic [15:0]       bd;
  logic signed [9:0] diff;
  logic signed [18:0] sd, dn, prod, num;
  logic [16:0]       adk;

  always_comb begin
    // earliest channel wins ties; zero distance never wins
    have = 1'b0;
    win  = 2'd0;
    if (d2_q[0] != '0) begin
      have = 1'b1;
      win  = 2'd0;
    end
    if (d2_q[1] != '0 && (!have || gt01_q)) begin
      have = 1'b1;
      win  = 2'd1;
    end
    if (d2_q[2] != '0 && (!have || (win == 2'd0 ? gt02_q : gt12_q))) begin
      have = 1'b1;
      win  = 2'd2;
    end
    dk   = have ? d2_q[win]   : '0;
    denk = have ? den2_q[win] : '0;

    mid_d      = '0;
    mid_d.none = !have;
    mid_d.src  = s2_q;
    dn         = $signed({11'b0, denk});
    for (int i = 0; i < 3; i++) begin
      bd   = 16'(b2_q[i]) * 16'(dk);
      diff = $signed({2'b0, s2_q[i]}) - $signed({2'b0, b2_q[i]});
      sd   = 19'(diff);
      prod = sd * dn;
      num  = $signed({3'b0, bd}) + prod;
      mid_d.neg[i] = num[18];
      mid_d.dvd[i] = {num[17:0], 1'b0} + 19'(dk);
      mid_d.dvs[i] = {dk, 1'b0};
    end
    adk          = 17'(16'(a2_q) * 16'(dk));
    mid_d.dvd[3] = {1'b0, adk, 1'b0} + 19'(denk);
    mid_d.dvs[3] = {denk, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q   <= src_i;
      a1_q   <= alpha_i;
      b1_q   <= bg_i;
      d1_q   <= d1_d;
      den1_q <= den1_d;
    end
    if (en[1]) begin
      s2_q   <= s1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      d2_q   <= d1_q;
      den2_q <= den1_q;
      gt01_q <= gt01_d;
      gt02_q <= gt02_d;
      gt12_q <= gt12_d;
    end
    if (en[2]) begin
      mid_q <= mid_d;
    end
  end

endmodule

@@ sv/cta_div.sv @@
// Pipelined restoring divider, four lanes, one quotient bit per stage, plus output mux.
// Depends on cta_pkg.
module cta_div import cta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  mid_valid_i,
  output logic  mid_ready_o,
  input  mid_t  mid_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rgb_t  out_rgb_o,
  output chan_t out_alpha_o
);

  logic  [NSteps:0] en;
  logic  [NSteps:0] v_q;
  dstg_t            stg_q [NSteps+1];
  dstg_t            stg_d [NSteps+1];

  always_comb begin
    en[NSteps] = !v_q[NSteps] || out_ready_i;
    for (int k = NSteps - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign mid_ready_o = en[0];
  assign out_valid_o = v_q[NSteps];

  // stage 0: saturation check, a red, green or blue quotient of 256 or more clamps
  always_comb begin
    stg_d[0]      = '0;
    stg_d[0].rem  = mid_i.dvd;
    stg_d[0].dvs  = mid_i.dvs;
    stg_d[0].neg  = mid_i.neg;
    stg_d[0].none = mid_i.none;
    stg_d[0].src  = mid_i.src;
    for (int l = 0; l < 3; l++) begin
      stg_d[0].sat[l] = mid_i.dvd[l] >= {2'b0, mid_i.dvs[l], 8'b0};
    end
  end

  for (genvar t = 1; t <= NSteps; t++) begin : g_step
    localparam int unsigned Bit = NSteps - t;
    logic [DvdW-1:0] trial [NLanes];
    always_comb begin
      stg_d[t] = stg_q[t-1];
      for (int l = 0; l < NLanes; l++) begin
        trial[l] = DvdW'(stg_q[t-1].dvs[l]) << Bit;
        if (stg_q[t-1].rem[l] >= trial[l]) begin
          stg_d[t].rem[l]      = stg_q[t-1].rem[l] - trial[l];
          stg_d[t].quo[l][Bit] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= mid_valid_i;
      for (int k = 1; k <= NSteps; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NSteps; k++) begin
      if (en[k]) stg_q[k] <= stg_d[k];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      priority if (stg_q[NSteps].none)   out_rgb_o[l] = stg_q[NSteps].src[l];
      else if (stg_q[NSteps].neg[l])     out_rgb_o[l] = '0;
      else if (stg_q[NSteps].sat[l])     out_rgb_o[l] = ChMax;
      else                               out_rgb_o[l] = stg_q[NSteps].quo[l];
    end
    out_alpha_o = stg_q[NSteps].none ? '0 : stg_q[NSteps].quo[3];
  end

endmodule

@@ tb/colour_to_alpha_unmix_chk.sv @@
// Checker for colour_to_alpha_unmix: watches the pixel channels and the register port,
// predicts each unmixed pixel and compares it field by field. Depends on cta_pkg.
module colour_to_alpha_unmix_chk import cta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_alpha_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_red_i,
  input  logic [7:0] out_green_i,
  input  logic [7:0] out_blue_i,
  input  logic [7:0] out_alpha_i,
  output int         errors_o,
  output int         pending_o,
  output int         pixels_o
);

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } pixel_t;

  pixel_t    unmixed_q[$];
  rgb_t      bg;
  int        errors;
  int        pixels;

  assign errors_o  = errors;
  assign pending_o = unmixed_q.size();
  assign pixels_o  = pixels;

  function automatic logic [7:0] unmix_chan(longint s, longint b, longint dk, longint denk);
    longint num;
    longint q;
    num = b * dk + (s - b) * denk;
    if (num < 0) return 8'd0;
    q = (2 * num + dk) / (2 * dk);
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic pixel_t predict_unmix(pixel_t src, rgb_t bgc);
    longint s[3], b[3];
    longint d, den, dk, denk;
    pixel_t res;
    s[0] = src.r; s[1] = src.g; s[2] = src.b;
    b[0] = bgc[REG_BG_RED]; b[1] = bgc[REG_BG_GREEN]; b[2] = bgc[REG_BG_BLUE];
    dk = 0;
    denk = 1;
    for (int i = 0; i < 3; i++) begin
      if (s[i] < b[i]) begin
        d = b[i] - s[i]; den = b[i];
      end else begin
        d = s[i] - b[i]; den = 255 - b[i];
      end
      // strictly larger only: earliest channel keeps a tie
      if (d != 0 && d * denk > dk * den) begin
        dk = d; denk = den;
      end
    end
    if (dk != 0) begin
      res.r = unmix_chan(s[0], b[0], dk, denk);
      res.g = unmix_chan(s[1], b[1], dk, denk);
      res.b = unmix_chan(s[2], b[2], dk, denk);
      res.a = 8'((2 * longint'(src.a) * dk + denk) / (2 * denk));
    end else begin
      res = src;
      res.a = 8'd0;
    end
    return res;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch pixel %0d %s: got %0d want %0d", pixels, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      bg = '{ChMax, ChMax, ChMax};
      errors = 0;
      pixels = 0;
      unmixed_q.delete();
    end else begin
      // inputs sampled at the edge before the register write takes effect
      if (in_valid_i && in_ready_i)
        unmixed_q.push_back(predict_unmix({src_red_i, src_green_i, src_blue_i, src_alpha_i}, bg));
      if (out_valid_i && out_ready_i) begin
        if (unmixed_q.size() == 0) begin
          $display("unexpected pixel out");
          errors++;
        end else begin
          want = unmixed_q.pop_front();
          if (out_red_i   !== want.r) report("red",   out_red_i,   want.r);
          if (out_green_i !== want.g) report("green", out_green_i, want.g);
          if (out_blue_i  !== want.b) report("blue",  out_blue_i,  want.b);
          if (out_alpha_i !== want.a) report("alpha", out_alpha_i, want.a);
        end
        pixels++;
      end
      if (cfg_we_i && cfg_idx_i <= REG_BG_BLUE) bg[cfg_idx_i] = cfg_data_i;
    end
  end

endmodule

@@ tb/colour_to_alpha_unmix_tb.sv @@
// Testbench top for colour_to_alpha_unmix: background register phases, directed and
// random pixel requests, random stalls on both sides. Depends on cta_pkg and the checker.
module colour_to_alpha_unmix_tb import cta_pkg::*;;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_BG_RED;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] src_red_i = '0, src_green_i = '0, src_blue_i = '0, src_alpha_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  int         errors, pending, pixels;
  int         sent;
  bit         hold_off;   // receiver blocks for a long stretch

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  colour_to_alpha_unmix u_dut (.*);

  colour_to_alpha_unmix_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .src_red_i, .src_green_i, .src_blue_i, .src_alpha_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .out_red_i(out_red_o), .out_green_i(out_green_o),
    .out_blue_i(out_blue_o), .out_alpha_i(out_alpha_o),
    .errors_o(errors), .pending_o(pending), .pixels_o(pixels)
  );

  // Offer one request after a random gap; valid holds until accepted.
  // With no gap, valid stays high into the next request.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    src_red_i   <= r;
    src_green_i <= g;
    src_blue_i  <= b;
    src_alpha_i <= a;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic set_bg(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [7:0] v[3];
    v = '{r, g, b};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly pixels near the background so that fractions stay small and
  // un-mixed colors land in range; some fully random.
  function automatic logic [7:0] near(logic [7:0] b);
    int v;
    if ($urandom_range(0, 2) == 0) return 8'($urandom);
    v = int'(b) + $urandom_range(0, 40) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Receiver: random stalls per request, plus one long hold-off.
  initial begin
    int wait_c;
    @(posedge rst_ni);
    forever begin
      wait_c = $urandom_range(0, 9);
      if ($urandom_range(0, 2) == 0) wait_c = 0;
      if (wait_c != 0 || hold_off) begin
        out_ready_i <= 1'b0;
        repeat (wait_c) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [7:0] bgs[8][3];
    bgs = '{'{255, 255, 255}, '{0, 0, 0}, '{128, 64, 200}, '{255, 0, 128},
            '{1, 254, 127}, '{37, 190, 90}, '{0, 255, 0}, '{200, 200, 10}};
    sent = 0;
    hold_off = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset background (white): extremes, exact match, ties, alpha ends.
    send_pixel(255, 255, 255, 255);
    send_pixel(0, 0, 0, 255);
    send_pixel(0, 0, 0, 0);
    send_pixel(128, 128, 128, 200);
    send_pixel(0, 255, 255, 255);
    send_pixel(100, 200, 50, 1);
    drain();

    set_bg(128, 64, 200);
    send_pixel(128, 64, 200, 255);   // background match
    send_pixel(0, 0, 0, 255);
    send_pixel(255, 255, 255, 255);
    send_pixel(0, 128, 255, 128);    // equal fractions on several channels
    send_pixel(255, 0, 200, 77);
    send_pixel(130, 60, 210, 255);
    send_pixel(129, 64, 200, 255);
    drain();

    set_bg(0, 255, 0);               // zero headroom on some sides
    send_pixel(0, 255, 0, 255);
    send_pixel(255, 0, 255, 255);
    send_pixel(1, 254, 1, 3);
    send_pixel(170, 85, 2, 254);
    drain();

    // Long receiver stall while requests keep coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    join
    drain();

    for (int p = 0; p < 8; p++) begin
      set_bg(bgs[p][0], bgs[p][1], bgs[p][2]);
      for (int i = 0; i < 225; i++)
        send_pixel(near(bgs[p][0]), near(bgs[p][1]), near(bgs[p][2]), 8'($urandom));
      drain();
    end
    set_bg(8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 50; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    drain();

    $display("%0d pixel requests sent, %0d checked, over 12 background settings", sent, pixels);
    $display("including white, black, mixed extremes and a long output stall");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

endmodule
